// File: hw/rtl/xtt_pkg.sv
// Shared types and constants of the XML tag tokenizer.
// Used by the front scanner, the back end and the top level.
`default_nettype none

package xtt_pkg;

    localparam int NAME_DEPTH_DEF = 64;
    localparam int CMD_DEPTH_DEF  = 4;
    localparam int LINE_W         = 32;

    // Kinds of result records.
    localparam logic [2:0] K_TEXT   = 3'd0;
    localparam logic [2:0] K_OPEN   = 3'd1;
    localparam logic [2:0] K_CLOSE  = 3'd2;
    localparam logic [2:0] K_SELF   = 3'd3;
    localparam logic [2:0] K_STATUS = 3'd4;

    // Commands passed from the scanner to the back end.
    localparam logic [1:0] OP_TEXT   = 2'd0;
    localparam logic [1:0] OP_NAME   = 2'd1;
    localparam logic [1:0] OP_EMPTY  = 2'd2;
    localparam logic [1:0] OP_STATUS = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic              closing;
        logic              self_close;
        logic [7:0]        data;
        logic              error;
        logic [LINE_W-1:0] lines;
    } t_cmd;

endpackage

`default_nettype wire

// File: hw/rtl/xtt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module xtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/xtt_front.sv
// Front scanner of the XML tag tokenizer: tag state machine, name buffer writes,
// newline count and sticky error. Depends on xtt_pkg.
`default_nettype none

module xtt_front import xtt_pkg::*; #(
    parameter int NAME_DEPTH = NAME_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_chunk_end,
    input  wire logic                          i_fifo_full,
    input  wire logic                          i_run_done,
    output logic                               o_full,
    output logic                               o_lock,
    output logic                               o_cmd_push,
    output t_cmd                               o_cmd,
    output logic [$clog2(NAME_DEPTH)-1:0]      o_cmd_len,
    output logic                               o_we,
    output logic [$clog2(NAME_DEPTH)-1:0]      o_waddr,
    output logic [7:0]                         o_wdata
);

    localparam int LW = $clog2(NAME_DEPTH);

    localparam logic [2:0] ST_TEXT  = 3'd0;
    localparam logic [2:0] ST_LT    = 3'd1;
    localparam logic [2:0] ST_FIRST = 3'd2;
    localparam logic [2:0] ST_LEAD  = 3'd3;
    localparam logic [2:0] ST_NAME  = 3'd4;
    localparam logic [2:0] ST_ATTR  = 3'd5;
    localparam logic [2:0] ST_SLASH = 3'd6;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    logic [2:0]        r_state, n_state;
    logic              r_closing, n_closing;
    logic              r_quotes, n_quotes;
    logic              r_error, n_error;
    logic [LW-1:0]     r_len, n_len;
    logic [LINE_W-1:0] r_lines, n_lines;
    logic              r_lock, n_lock;

    logic              accept;
    logic              cmd_valid;
    logic              add;
    logic [2:0]        eff;
    logic              is_sp, is_al, is_dg;
    logic [7:0]        c;

    assign o_full = i_fifo_full || r_lock;
    assign accept = i_push && !o_full;
    assign o_lock = r_lock;
    assign c      = i_data_byte;

    always_comb begin
        n_state   = r_state;
        n_closing = r_closing;
        n_quotes  = r_quotes;
        n_error   = r_error;
        n_len     = r_len;
        n_lines   = r_lines;
        cmd_valid = 1'b0;
        add       = 1'b0;
        o_cmd     = '0;
        eff       = r_state;
        is_sp = (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h20);
        is_al = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
        is_dg = (c >= 8'h30) && (c <= 8'h39);

        if (!r_error) begin
            if (c == CH_LF) begin
                n_lines = r_lines + 1'b1;
            end
            // A '<' not followed by '/' goes straight to first-name handling,
            // and the first non-space after the lead goes to name handling.
            if (r_state == ST_LT) begin
                eff = (c == CH_SLASH) ? ST_LT : ST_FIRST;
            end else if ((r_state == ST_LEAD) && !is_sp) begin
                eff = ST_NAME;
            end
            n_state = eff;

            case (eff)
                ST_LT: begin
                    n_closing = 1'b1;
                    n_state   = ST_LEAD;
                end
                ST_FIRST: begin
                    if (!is_sp) begin
                        if (is_al) begin
                            add     = 1'b1;
                            n_state = ST_LEAD;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                end
                ST_LEAD: begin
                end
                ST_NAME: begin
                    if (c == CH_COLON) begin
                        n_len = '0;
                    end else if (is_sp || (c == CH_GT)) begin
                        cmd_valid     = 1'b1;
                        o_cmd.op      = (r_len == '0) ? OP_EMPTY : OP_NAME;
                        o_cmd.closing = r_closing;
                        n_len         = '0;
                        n_closing     = 1'b0;
                        n_quotes      = 1'b0;
                        n_state       = is_sp ? ST_ATTR : ST_TEXT;
                    end else if (is_al || is_dg || (c == CH_UNDER) || (c == CH_DASH)) begin
                        add = 1'b1;
                    end else if (c == CH_SLASH) begin
                        n_state = ST_SLASH;
                    end else begin
                        n_error = 1'b1;
                    end
                end
                ST_ATTR: begin
                    if (r_quotes) begin
                        if (c == CH_QUOTE) begin
                            n_quotes = 1'b0;
                        end
                    end else if (c == CH_QUOTE) begin
                        n_quotes = 1'b1;
                    end else if (c == CH_SLASH) begin
                        n_state = ST_SLASH;
                    end else if (c == CH_GT) begin
                        n_state = ST_TEXT;
                    end
                end
                ST_SLASH: begin
                    if (c != CH_GT) begin
                        n_error = 1'b1;
                    end else begin
                        cmd_valid        = 1'b1;
                        o_cmd.op         = OP_NAME;
                        o_cmd.self_close = 1'b1;
                        n_len            = '0;
                        n_closing        = 1'b0;
                        n_quotes         = 1'b0;
                        n_state          = ST_TEXT;
                    end
                end
                default: begin
                    if (c == CH_LT) begin
                        n_state = ST_LT;
                    end else begin
                        cmd_valid  = 1'b1;
                        o_cmd.op   = OP_TEXT;
                        o_cmd.data = c;
                    end
                end
            endcase

            // Name bytes past the buffer's last usable entry are dropped.
            if (add && (r_len < LW'(NAME_DEPTH - 1))) begin
                n_len = r_len + 1'b1;
            end else begin
                add = 1'b0;
            end
        end

        if (!cmd_valid && i_chunk_end) begin
            cmd_valid = 1'b1;
            o_cmd.op  = OP_STATUS;
        end
        o_cmd.error = n_error;
        o_cmd.lines = n_lines;

        n_lock = r_lock;
        if (i_run_done) begin
            n_lock = 1'b0;
        end
        if (accept && cmd_valid && (o_cmd.op == OP_NAME)) begin
            n_lock = 1'b1;
        end
    end

    assign o_cmd_push = accept && cmd_valid;
    assign o_cmd_len  = r_len;
    assign o_we       = accept && add;
    assign o_waddr    = r_len;
    assign o_wdata    = c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_TEXT;
            r_closing <= 1'b0;
            r_quotes  <= 1'b0;
            r_error   <= 1'b0;
            r_len     <= '0;
            r_lines   <= '0;
            r_lock    <= 1'b0;
        end else begin
            r_lock <= n_lock;
            if (accept) begin
                r_state   <= n_state;
                r_closing <= n_closing;
                r_quotes  <= n_quotes;
                r_error   <= n_error;
                r_len     <= n_len;
                r_lines   <= n_lines;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/xtt_cmd_fifo.sv
// Short command queue between the front scanner and the back end.
// Depends on nothing but its parameters.
`default_nettype none

module xtt_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/xtt_back.sv
// Back end of the XML tag tokenizer: turns commands into result records and
// replays tag names from the name RAM. Depends on xtt_pkg.
`default_nettype none

module xtt_back import xtt_pkg::*; #(
    parameter int NAME_DEPTH = NAME_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_empty,
    input  wire t_cmd                          i_cmd,
    input  wire logic [$clog2(NAME_DEPTH)-1:0] i_cmd_len,
    output logic                               o_cmd_pop,
    output logic                               o_rd_en,
    output logic [$clog2(NAME_DEPTH)-1:0]      o_rd_addr,
    input  wire logic [7:0]                    i_rd_data,
    output logic                               o_run_done,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output logic [2:0]                         o_kind,
    output logic [7:0]                         o_data_byte_out,
    output logic                               o_empty_name,
    output logic                               o_last,
    output logic                               o_error,
    output logic [LINE_W-1:0]                  o_line_count
);

    localparam int LW = $clog2(NAME_DEPTH);

    // Output record register.
    logic              r_valid;
    logic [2:0]        r_kind, n_kind;
    logic [7:0]        r_byte, n_byte;
    logic              r_ename, n_ename;
    logic              r_last, n_last;
    logic              r_err, n_err;
    logic [LINE_W-1:0] r_lines, n_lines;

    // Name replay state.
    logic              r_run;
    logic [LW-1:0]     r_len;
    logic [LW-1:0]     r_sent;
    logic [LW-1:0]     r_rd_idx;
    logic              r_data_ok;
    logic              r_self;
    logic              r_closing;
    logic              r_rerr;
    logic [LINE_W-1:0] r_rlines;

    logic out_free, xfer, marker, load, start;

    assign out_free  = !r_valid || i_pop;
    assign o_cmd_pop = !r_run && !i_cmd_empty && out_free;
    assign start     = o_cmd_pop && (i_cmd.op == OP_NAME);
    assign xfer      = r_run && r_data_ok && out_free;
    assign marker    = r_run && !r_data_ok && (r_sent == r_len) && r_self && out_free;
    assign o_rd_en   = r_run && (r_rd_idx < r_len) && (!r_data_ok || xfer);
    assign o_rd_addr = r_rd_idx;
    assign o_run_done = marker || (xfer && !r_self && (r_sent == r_len - 1'b1));

    always_comb begin
        load    = 1'b0;
        n_kind  = r_kind;
        n_byte  = r_byte;
        n_ename = 1'b0;
        n_last  = 1'b1;
        n_err   = r_err;
        n_lines = r_lines;
        if (xfer) begin
            load    = 1'b1;
            n_kind  = r_closing ? K_CLOSE : K_OPEN;
            n_byte  = i_rd_data;
            n_last  = (r_sent == r_len - 1'b1) && !r_self;
            n_err   = r_rerr;
            n_lines = r_rlines;
        end else if (marker) begin
            load    = 1'b1;
            n_kind  = K_SELF;
            n_byte  = '0;
            n_err   = r_rerr;
            n_lines = r_rlines;
        end else if (o_cmd_pop && !start) begin
            load    = 1'b1;
            n_err   = i_cmd.error;
            n_lines = i_cmd.lines;
            n_byte  = '0;
            case (i_cmd.op)
                OP_TEXT: begin
                    n_kind = K_TEXT;
                    n_byte = i_cmd.data;
                end
                OP_EMPTY: begin
                    n_kind  = i_cmd.closing ? K_CLOSE : K_OPEN;
                    n_ename = 1'b1;
                end
                default: begin
                    n_kind = K_STATUS;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= n_kind;
            r_byte  <= n_byte;
            r_ename <= n_ename;
            r_last  <= n_last;
            r_err   <= n_err;
            r_lines <= n_lines;
        end
        if (start) begin
            r_len     <= i_cmd_len;
            r_self    <= i_cmd.self_close;
            r_closing <= i_cmd.closing;
            r_rerr    <= i_cmd.error;
            r_rlines  <= i_cmd.lines;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_run     <= 1'b0;
            r_sent    <= '0;
            r_rd_idx  <= '0;
            r_data_ok <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end

            if (start) begin
                r_run     <= 1'b1;
                r_sent    <= '0;
                r_rd_idx  <= '0;
                r_data_ok <= 1'b0;
            end else begin
                if (o_run_done) begin
                    r_run <= 1'b0;
                end
                if (o_rd_en) begin
                    r_rd_idx  <= r_rd_idx + 1'b1;
                    r_data_ok <= 1'b1;
                end else if (xfer) begin
                    r_data_ok <= 1'b0;
                end
                if (xfer) begin
                    r_sent <= r_sent + 1'b1;
                end
            end
        end
    end

    assign o_empty         = !r_valid;
    assign o_kind          = r_kind;
    assign o_data_byte_out = r_byte;
    assign o_empty_name    = r_ename;
    assign o_last          = r_last;
    assign o_error         = r_err;
    assign o_line_count    = r_lines;

endmodule

`default_nettype wire

// File: hw/rtl/xml_tag_tokenizer.sv
// Top level of the XML tag tokenizer: front scanner, command queue, name RAM
// and back end. Depends on xtt_pkg, xtt_front, xtt_cmd_fifo, xtt_ram, xtt_back.
//
// The tokenizer takes one document byte per transaction on the push/full side
// and delivers result records on the empty/pop side. Text bytes outside tags
// come out as one text record each, and a run of text is taken at one byte per
// clock as long as the result side keeps popping. Tag names are written into a
// name RAM of NAME_DEPTH entries (at most NAME_DEPTH-1 bytes are kept) while the
// tag is scanned; at the end of the name the scanner posts a command into a
// CMD_DEPTH-entry queue; the back end replays the name from the RAM at one record
// per clock while results are popped, then a self-close marker for a "/>" tag.
// From the byte that ends a name until the last record of that name, or its
// self-close marker, has been loaded into the output register, full stays high.
// With the queue otherwise empty and the result side popping, the hold on full
// covers taking the command, the registered read of the first byte, then one
// record per name byte, and the self-close marker when the tag ends in "/>".
// The name RAM's single read port and its registered read set these steps, and a
// slow result side or commands queued ahead stretch the hold on full. full also
// rises when the command queue is full. Every record carries the sticky error
// flag and the newline count as they stood after the byte that caused it, and
// last marks the final record of that byte. A byte with chunk_end set that
// yields no other record yields a status record. After a syntax error, bytes are
// still taken but produce nothing except those status records.
`default_nettype none

module xml_tag_tokenizer import xtt_pkg::*; #(
    parameter int NAME_DEPTH = NAME_DEPTH_DEF,
    parameter int CMD_DEPTH  = CMD_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_chunk_end,
    output logic                   empty,
    input  wire logic              pop,
    output logic [2:0]             o_kind,
    output logic [7:0]             o_data_byte_out,
    output logic                   o_empty_name,
    output logic                   o_last,
    output logic                   o_error,
    output logic [LINE_W-1:0]      o_line_count
);

    localparam int LW = $clog2(NAME_DEPTH);
    localparam int QW = $bits(t_cmd) + LW;

    // Front to queue.
    logic          w_cmd_push;
    t_cmd          w_front_cmd;
    logic [LW-1:0] w_front_len;
    logic          w_fifo_full;
    logic          w_fifo_empty;
    logic          w_cmd_pop;
    logic [QW-1:0] w_fifo_rdata;
    t_cmd          w_back_cmd;
    logic [LW-1:0] w_back_len;

    // Name RAM ports.
    logic          w_ram_we;
    logic [LW-1:0] w_ram_waddr;
    logic [7:0]    w_ram_wdata;
    logic          w_ram_re;
    logic [LW-1:0] w_ram_raddr;
    logic [7:0]    w_ram_rdata;

    logic          w_run_done;
    logic          w_name_lock;

    xtt_front #(
        .NAME_DEPTH (NAME_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_chunk_end (i_chunk_end),
        .i_fifo_full (w_fifo_full),
        .i_run_done  (w_run_done),
        .o_full      (full),
        .o_lock      (w_name_lock),
        .o_cmd_push  (w_cmd_push),
        .o_cmd       (w_front_cmd),
        .o_cmd_len   (w_front_len),
        .o_we        (w_ram_we),
        .o_waddr     (w_ram_waddr),
        .o_wdata     (w_ram_wdata)
    );

    xtt_cmd_fifo #(
        .WIDTH (QW),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_wdata ({w_front_len, w_front_cmd}),
        .i_pop   (w_cmd_pop),
        .o_rdata (w_fifo_rdata),
        .o_full  (w_fifo_full),
        .o_empty (w_fifo_empty)
    );

    assign w_back_cmd = w_fifo_rdata[$bits(t_cmd)-1:0];
    assign w_back_len = w_fifo_rdata[QW-1:$bits(t_cmd)];

    xtt_ram #(
        .WIDTH (8),
        .DEPTH (NAME_DEPTH)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    xtt_back #(
        .NAME_DEPTH (NAME_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_empty     (w_fifo_empty),
        .i_cmd           (w_back_cmd),
        .i_cmd_len       (w_back_len),
        .o_cmd_pop       (w_cmd_pop),
        .o_rd_en         (w_ram_re),
        .o_rd_addr       (w_ram_raddr),
        .i_rd_data       (w_ram_rdata),
        .o_run_done      (w_run_done),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_kind          (o_kind),
        .o_data_byte_out (o_data_byte_out),
        .o_empty_name    (o_empty_name),
        .o_last          (o_last),
        .o_error         (o_error),
        .o_line_count    (o_line_count)
    );

    // The name RAM is never written while a name is still being replayed.
    a_no_write_during_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_name_lock |-> !w_ram_we)
        else $error("name RAM written while a name replay is outstanding");

    // A replay can only finish when the scanner is holding off for it.
    a_done_needs_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_run_done |-> w_name_lock)
        else $error("name replay finished without an outstanding name command");

    // The error flag seen on the result side never goes back to zero.
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_error) |=> (empty || o_error))
        else $error("error flag cleared on a later record");

endmodule

`default_nettype wire
